/* rtl/span39_pkg.sv */
// Shared types, codes and constants for the span-3 to span-9 plane mapper.
// No dependencies; every rtl module imports this package.
package span39_pkg;

  localparam int RING_W   = 9;
  localparam int MRD_W    = 8;
  localparam int SEG_W    = 8;
  localparam int PLANE_W  = 9;
  localparam int ADDR_W   = 17;
  localparam int OP_W     = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // plane operation codes
  localparam logic [OP_W-1:0] OP_KEEP = 2'd0;
  localparam logic [OP_W-1:0] OP_COPY = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd2;

  // register select (paddr[2])
  localparam logic REG_RING_COUNT   = 1'b0;
  localparam logic REG_MAX_RING_DIF = 1'b1;

  localparam logic [RING_W-1:0] RING_COUNT_RST   = 9'd104;
  localparam logic [MRD_W-1:0]  MAX_RING_DIF_RST = 8'd67;

  // reciprocal multipliers: x/3 = (x*171)>>9 for x<512, x/9 = (x*911)>>13 for x<1024
  localparam logic [7:0] DIV3_MUL = 8'd171;
  localparam int         DIV3_SH  = 9;
  localparam logic [9:0] DIV9_MUL = 10'd911;
  localparam int         DIV9_SH  = 13;

  typedef struct packed {
    logic [RING_W-1:0] ring_count;
    logic [MRD_W-1:0]  max_ring_difference;
  } cfg_t;

  // after index decode
  typedef struct packed {
    logic              seg_zero;
    logic              group_zero;
    logic              plane_ok;
    logic              tail_odd;
    logic [SEG_W-1:0]  seg_idx;
    logic [7:0]        nseg3;
    logic [5:0]        nseg9;
    logic [5:0]        group;
    logic [6:0]        half;
    logic [2:0]        slot;
    logic [1:0]        shift;
    logic [7:0]        smax;
    logic [5:0]        hmax;
    logic [PLANE_W-1:0] plane;
  } stage_a_t;

  // after the products
  typedef struct packed {
    logic               seg_zero;
    logic               group_zero;
    logic               used;
    logic [OP_W-1:0]    op;
    logic [9:0]         p0;
    logic [16:0]        prod_a;
    logic [14:0]        prod_b;
    logic [16:0]        prod_c;
    logic [12:0]        prod_d;
    logic [9:0]         tail_src;
    logic [10:0]        tail_dst;
    logic [1:0]         shift;
    logic [PLANE_W-1:0] plane;
  } stage_b_t;

endpackage

/* rtl/span3_to_span9_plane_mapper_unit.sv */
// Top level of the span-3 to span-9 plane mapper: register file, pipeline, result stage.
// Depends on span39_pkg, span39_cfg, span39_decode and span39_mult.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+--------------------------------------
//  config    | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//  item in   | start while busy is low        | segment_index, plane_index
//  result    | done, one cycle strobe         | source_plane, dest_plane, operation,
//            |                                | dropped
//
// One item per cycle while busy is low; each item passes the registered decode stage,
// product stage and sum and output stage in that order before its result appears.
// rst is synchronous; busy is rst registered once, so it stays high through reset and for the cycle after.
// The receiver cannot stall, so the pipeline never holds and busy is low otherwise.
module span3_to_span9_plane_mapper_unit import span39_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [SEG_W-1:0]   segment_index,
  input  logic [PLANE_W-1:0] plane_index,
  output logic               done,
  output logic [ADDR_W-1:0]  source_plane,
  output logic [ADDR_W-1:0]  dest_plane,
  output logic [OP_W-1:0]    operation,
  output logic               dropped
);

  cfg_t        cfg;
  logic        accept, a_valid, b_valid;
  stage_a_t    a;
  stage_b_t    b;
  logic [16:0] three_b, nine_d, diff_ab, diff_cd, src_sum, dst_sum;
  logic [16:0] plane_w;

  span39_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start & ~busy;

  span39_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .segment_index (segment_index),
    .plane_index   (plane_index),
    .cfg           (cfg),
    .a_valid       (a_valid),
    .a             (a)
  );

  span39_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .a_valid (a_valid),
    .a       (a),
    .cfg     (cfg),
    .b_valid (b_valid),
    .b       (b)
  );

  // sums wrap to the 17-bit plane address
  always_comb begin
    plane_w = {8'b0, b.plane};
    three_b = {2'b00, b.prod_b} + {1'b0, b.prod_b, 1'b0};
    nine_d  = {4'b0, b.prod_d} + {1'b0, b.prod_d, 3'b000};
    diff_ab = b.prod_a - three_b;
    diff_cd = b.prod_c - nine_d;
    // both signs of each full pair count, so double the run sums
    src_sum = {7'b0, b.p0} + {diff_ab[15:0], 1'b0} + {7'b0, b.tail_src} + plane_w;
    // centering shift moves in steps of three planes
    dst_sum = {7'b0, b.p0} + {diff_cd[15:0], 1'b0} + {6'b0, b.tail_dst}
            + {15'b0, b.shift} + {14'b0, b.shift, 1'b0} + plane_w;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      dropped <= ~b.used;
      if (!b.used) begin
        source_plane <= '0;
        dest_plane   <= '0;
        operation    <= OP_KEEP;
      end else begin
        operation    <= b.op;
        source_plane <= b.seg_zero ? plane_w : src_sum;
        if (b.seg_zero)
          dest_plane <= plane_w;
        else if (b.group_zero)
          dest_plane <= plane_w + 17'd2;
        else
          dest_plane <= dst_sum;
      end
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted beat produced no result three cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without a matching start beat");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    done && dropped |-> source_plane == '0 && dest_plane == '0 && operation == OP_KEEP)
    else $error("dropped result carries nonzero fields");

  a_keep_same: assert property (@(posedge clk) disable iff (rst)
    done && !dropped && operation == OP_KEEP |-> dest_plane == source_plane)
    else $error("segment zero plane not kept in place");

endmodule

/* rtl/span39_cfg.sv */
// APB register file: ring count and maximum ring difference.
// Depends on span39_pkg.
module span39_cfg import span39_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_count          <= RING_COUNT_RST;
      cfg.max_ring_difference <= MAX_RING_DIF_RST;
    end else if (wr) begin
      case (paddr[2])
        REG_RING_COUNT:   cfg.ring_count          <= pwdata[RING_W-1:0];
        REG_MAX_RING_DIF: cfg.max_ring_difference <= pwdata[MRD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RING_COUNT:   prdata = {{(PDATA_W-RING_W){1'b0}}, cfg.ring_count};
      REG_MAX_RING_DIF: prdata = {{(PDATA_W-MRD_W){1'b0}}, cfg.max_ring_difference};
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/span39_decode.sv */
// First pipeline stage: segment, group and pair decode, segment counts, plane range.
// Depends on span39_pkg.
module span39_decode import span39_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [SEG_W-1:0]   segment_index,
  input  logic [PLANE_W-1:0] plane_index,
  input  cfg_t               cfg,
  output logic               a_valid,
  output stage_a_t           a
);

  logic [8:0]  i1, i3, two_m1, six_g, j9;
  logic [7:0]  s, ih, three_g, sh8, im1;
  logic [16:0] g_prod, n3_prod, smax_prod;
  logic [18:0] n9_prod, hmax_prod;
  logic [9:0]  r3;
  logic [5:0]  g;
  logic [10:0] six_s, two_r, p11;
  logic        plane_ok;
  stage_a_t    a_next;

  always_comb begin
    i1     = {1'b0, segment_index} + 9'd1;
    i3     = {1'b0, segment_index} + 9'd3;
    s      = i1[8:1];
    ih     = i3[8:1];
    g_prod = {9'b0, ih} * {9'b0, DIV3_MUL};
    g      = g_prod[DIV3_SH+5:DIV3_SH];
    im1    = segment_index - 8'd1;

    two_m1  = {cfg.max_ring_difference, 1'b1};
    n3_prod = {8'b0, two_m1} * {9'b0, DIV3_MUL};
    n9_prod = {10'b0, two_m1} * {9'b0, DIV9_MUL};

    smax_prod = {8'b0, cfg.ring_count} * {9'b0, DIV3_MUL};
    r3        = {1'b0, cfg.ring_count} + 10'd3;
    hmax_prod = {9'b0, r3} * {9'b0, DIV9_MUL};

    six_g   = {1'b0, g, 2'b00} + {2'b00, g, 1'b0};
    j9      = i3 - six_g;
    three_g = {1'b0, g, 1'b0} + {2'b00, g};
    sh8     = s + 8'd1 - three_g;

    // plane range: p < 2R-1 for segment 0, p < 2R+1-6s otherwise
    six_s = {1'b0, s, 2'b00} + {2'b00, s, 1'b0};
    two_r = {1'b0, cfg.ring_count, 1'b0};
    p11   = {2'b00, plane_index};
    if (segment_index == '0)
      plane_ok = (p11 + 11'd1) < two_r;
    else
      plane_ok = (p11 + six_s) <= two_r;

    a_next.seg_zero   = (segment_index == '0);
    a_next.group_zero = (g == '0);
    a_next.plane_ok   = plane_ok;
    a_next.tail_odd   = im1[0];
    a_next.seg_idx    = segment_index;
    a_next.nseg3      = n3_prod[DIV3_SH+7:DIV3_SH];
    a_next.nseg9      = n9_prod[DIV9_SH+5:DIV9_SH];
    a_next.group      = g;
    a_next.half       = im1[7:1];
    a_next.slot       = j9[2:0];
    a_next.shift      = sh8[1:0];
    a_next.smax       = smax_prod[DIV3_SH+7:DIV3_SH];
    a_next.hmax       = hmax_prod[DIV9_SH+5:DIV9_SH];
    a_next.plane      = plane_index;
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else     a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid) a <= a_next;
  end

endmodule

/* rtl/span39_mult.sv */
// Second pipeline stage: use check, clamped run lengths and the prefix-sum products.
// Depends on span39_pkg.
module span39_mult import span39_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     a_valid,
  input  stage_a_t a,
  input  cfg_t     cfg,
  output logic     b_valid,
  output stage_b_t b
);

  logic        seg_ok, group_ok;
  logic [6:0]  qc, two_g_m1;
  logic [7:0]  qc1, q1;
  logic [5:0]  gm1, gc;
  logic [6:0]  gc1;
  logic [9:0]  r2p1;
  logic [10:0] r2p1_w, r2p7, six_q1, eighteen_g;
  stage_b_t    b_next;

  always_comb begin
    seg_ok   = a.seg_idx < a.nseg3;
    two_g_m1 = {a.group, 1'b0} - 7'd1;
    group_ok = a.group_zero ? (a.nseg9 != '0) : (two_g_m1 < {1'b0, a.nseg9});

    // clamp run lengths to the segments that still have planes
    qc  = ({1'b0, a.half} < a.smax) ? a.half : a.smax[6:0];
    qc1 = {1'b0, qc} + 8'd1;
    gm1 = a.group - 6'd1;
    gc  = (gm1 < a.hmax) ? gm1 : a.hmax;
    gc1 = {1'b0, gc} + 7'd1;

    r2p1   = {cfg.ring_count, 1'b1};
    r2p1_w = {1'b0, r2p1};
    r2p7   = {1'b0, cfg.ring_count, 1'b0} + 11'd7;

    q1         = {1'b0, a.half} + 8'd1;
    six_q1     = {1'b0, q1, 2'b00} + {2'b00, q1, 1'b0};
    eighteen_g = {1'b0, a.group, 4'b0000} + {4'b0000, a.group, 1'b0};

    b_next.seg_zero   = a.seg_zero;
    b_next.group_zero = a.group_zero;
    b_next.used       = seg_ok & group_ok & a.plane_ok;
    if (a.seg_zero)
      b_next.op = OP_KEEP;
    else if (a.group_zero)
      b_next.op = OP_ADD;
    else if (a.slot < 3'd2)
      b_next.op = OP_COPY;
    else
      b_next.op = OP_ADD;
    b_next.p0     = (cfg.ring_count == '0) ? 10'd0 : ({cfg.ring_count, 1'b0} - 10'd1);
    b_next.prod_a = {10'b0, qc} * {7'b0, r2p1};
    b_next.prod_b = {8'b0, qc} * {7'b0, qc1};
    b_next.prod_c = {11'b0, gc} * {6'b0, r2p7};
    b_next.prod_d = {7'b0, gc} * {6'b0, gc1};
    // odd leftover segment of the prefix, and the positive half of the group
    b_next.tail_src = (a.tail_odd && six_q1 < r2p1_w) ? 10'(r2p1_w - six_q1) : 10'd0;
    b_next.tail_dst = (a.slot[0] && eighteen_g < r2p7) ? (r2p7 - eighteen_g) : 11'd0;
    b_next.shift    = a.shift;
    b_next.plane    = a.plane;
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (a_valid) b <= b_next;
  end

endmodule
